// ===== rtl/core/text_glyph_pixel_renderer_macros.svh =====
// Assertion macros for the text glyph pixel renderer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TEXT_GLYPH_PIXEL_RENDERER_MACROS_SVH
`define TEXT_GLYPH_PIXEL_RENDERER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TGPR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgpr: implication check failed");
// next-cycle implication
`define TGPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tgpr: next-cycle check failed");
// condition that must never hold
`define TGPR_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tgpr: forbidden condition seen");
`else
`define TGPR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TGPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`define TGPR_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/core/tgpr_pkg.sv =====
// Shared types and constants for the text glyph pixel renderer.
// No dependencies; imported by every module of the block.
package tgpr_pkg;

   // glyph geometry
   localparam int GLYPH_ROWS  = 8;
   localparam int GLYPH_COLS  = 8;
   localparam int GLYPH_COUNT = 256;
   localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
   localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int ROW_AW      = $clog2(GLYPH_ROWS);
   localparam int BIT_AW      = $clog2(GLYPH_BITS);

   // port widths
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_DATA_W  = 32;

   // special character codes
   localparam logic [7:0] CODE_NEWLINE   = 8'd10;
   localparam logic [7:0] CODE_BACKSPACE = 8'd8;
   localparam logic [7:0] GLYPH_SOLID    = 8'd219;

   localparam logic [12:0] SCREEN_WIDTH_RESET = 13'd1024;

   typedef enum logic [1:0] {
      CMD_PUT        = 2'd0,
      CMD_SET_CURSOR = 2'd1,
      CMD_LOAD_ROW   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_FRAME_BASE   = 2'd0,
      CSR_SCREEN_WIDTH = 2'd1,
      CSR_BG_COLOR     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LAUNCH,
      ST_DRAW
   } state_type;

   // one character to draw: cell position, color and transposed glyph bits
   // (bit gx*GLYPH_ROWS+gy is glyph column gx, glyph row gy)
   typedef struct packed {
      logic [8:0]            col;
      logic [8:0]            row;
      logic [31:0]           color;
      logic [GLYPH_BITS-1:0] bits;
   } draw_job_type;

endpackage

// ===== rtl/core/text_glyph_pixel_renderer.sv =====
// Top level of the text glyph pixel renderer: request decode, cursor,
// configuration registers and glyph fetch sequencing.
// Depends on tgpr_pkg, tgpr_glyph_store, tgpr_pixel_gen and the macro header.
//
// Usage: requests arrive on req_* (tuser = command). Put character draws the
// glyph at the cursor and advances it; newline and backspace move the cursor
// (backspace paints glyph 219 in the background color); set cursor and load
// glyph row take effect in the cycle of acceptance. Each set glyph bit gives
// one pixel write on rsp_*, column-major, with tlast on the final one.
// Drawing: a drawing request fetches eight glyph rows from the glyph store
// (one read port, one row a cycle), then hands the glyph to the pixel
// generator, which scans the glyph bits up to the last set one and gives
// a pixel write for each set bit. Commands that draw nothing leave the
// block idle and ready for the next request.
// Only one request is in work at a time; req_tready is high in idle. The
// final pixel can wait in the output register while the next request is taken.
// A stall on rsp_tready holds the scan in place; nothing is dropped.
// Reset (synchronous) clears the cursor and loads the register defaults;
// the glyph store is not cleared and must be loaded before use.
`include "text_glyph_pixel_renderer_macros.svh"
module text_glyph_pixel_renderer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // char_code[7:0], draw_color[39:8], cursor_col_in[48:40], cursor_row_in[57:49],
   // glyph_row_index[60:58], glyph_row_bits[68:61], zero pad[71:69]
   input  logic [tgpr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // cmd[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_address[31:0], pixel_color[63:32]
   output logic [tgpr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [tgpr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tgpr_pkg::*;

   // request fields
   cmd_type               req_cmd;
   logic [7:0]            req_char;
   logic [31:0]           req_color;
   logic [8:0]            req_col;
   logic [8:0]            req_row;
   logic [ROW_AW-1:0]     req_grow;
   logic [GLYPH_COLS-1:0] req_gbits;
   logic                  req_fire;

   // configuration
   logic [31:0]           frame_base_ff;
   logic [12:0]           screen_width_ff;
   logic [31:0]           bg_color_ff;

   // control
   state_type             state_ff, state_in;
   logic [8:0]            col_ff, col_in;
   logic [8:0]            row_ff, row_in;
   logic [8:0]            draw_col_ff, draw_col_in;
   logic [8:0]            draw_row_ff, draw_row_in;
   logic [31:0]           draw_color_ff, draw_color_in;
   logic [7:0]            draw_code_ff, draw_code_in;
   logic [ROW_AW:0]       rd_cnt_ff, rd_cnt_in;
   logic                  rd_pend_ff;
   logic [ROW_AW-1:0]     rd_row_ff;
   logic [GLYPH_BITS-1:0] glyph_ff, glyph_in;

   logic [9:0]            cell_cnt;
   logic [9:0]            bs_col;
   logic                  wrap;
   logic [8:0]            put_col;
   logic [8:0]            put_row;
   logic                  go_draw;

   logic                  mem_we;
   logic                  mem_re;
   logic [GLYPH_COLS-1:0] mem_rdata;
   logic                  job_start;
   logic                  draw_busy;
   draw_job_type          job;

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_char  = req_tdata[7:0];
   assign req_color = req_tdata[39:8];
   assign req_col   = req_tdata[48:40];
   assign req_row   = req_tdata[57:49];
   assign req_grow  = req_tdata[60:58];
   assign req_gbits = req_tdata[68:61];
   assign req_fire  = req_tvalid && req_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff   <= '0;
         screen_width_ff <= SCREEN_WIDTH_RESET;
         bg_color_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_BASE:   frame_base_ff   <= csr_wdata;
            CSR_SCREEN_WIDTH: screen_width_ff <= csr_wdata[12:0];
            CSR_BG_COLOR:     bg_color_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // cursor update, draw setup, row fetch counter and glyph capture
   always_comb begin
      cell_cnt      = screen_width_ff[12:3];
      bs_col        = ({1'b0, col_ff} < cell_cnt) ? {1'b0, col_ff} : cell_cnt;
      wrap          = ({1'b0, col_ff} >= cell_cnt);
      put_col       = wrap ? 9'd0 : col_ff;
      put_row       = wrap ? 9'(row_ff + 9'd1) : row_ff;
      go_draw       = 1'b0;
      col_in        = col_ff;
      row_in        = row_ff;
      draw_col_in   = draw_col_ff;
      draw_row_in   = draw_row_ff;
      draw_color_in = draw_color_ff;
      draw_code_in  = draw_code_ff;
      rd_cnt_in     = rd_cnt_ff;
      glyph_in      = glyph_ff;
      if (req_fire) begin
         rd_cnt_in = '0;
         case (req_cmd)
            CMD_SET_CURSOR: begin
               col_in = req_col;
               row_in = req_row;
            end
            CMD_PUT: begin
               if (req_char == CODE_NEWLINE) begin
                  col_in = '0;
                  row_in = 9'(row_ff + 9'd1);
               end else if (req_char == CODE_BACKSPACE) begin
                  // column saturates to the line length, then steps back
                  if (bs_col != '0) begin
                     go_draw       = 1'b1;
                     col_in        = 9'(bs_col - 10'd1);
                     draw_col_in   = 9'(bs_col - 10'd1);
                     draw_row_in   = row_ff;
                     draw_code_in  = GLYPH_SOLID;
                     draw_color_in = bg_color_ff;
                  end
               end else begin
                  go_draw       = 1'b1;
                  draw_col_in   = put_col;
                  draw_row_in   = put_row;
                  col_in        = 9'(put_col + 9'd1);
                  row_in        = put_row;
                  draw_code_in  = req_char;
                  draw_color_in = req_color;
               end
            end
            default: ;
         endcase
      end
      if (state_ff == ST_READ) begin
         if (!rd_cnt_ff[ROW_AW]) begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
         end
         // scatter the arriving row into the column-major bit order
         if (rd_pend_ff) begin
            for (int gx = 0; gx < GLYPH_COLS; gx++) begin
               glyph_in[{3'(gx), rd_row_ff}] = mem_rdata[gx];
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire && go_draw) state_in = ST_READ;
         ST_READ:   if (rd_cnt_ff[ROW_AW]) state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_DRAW;
         ST_DRAW:   if (!draw_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      mem_re     = 1'b0;
      job_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_READ:   mem_re     = !rd_cnt_ff[ROW_AW];
         ST_LAUNCH: job_start  = 1'b1;
         ST_DRAW:   ;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         col_ff     <= '0;
         row_ff     <= '0;
         rd_cnt_ff  <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         rd_cnt_ff  <= rd_cnt_in;
         rd_pend_ff <= mem_re;
      end
      rd_row_ff     <= rd_cnt_ff[ROW_AW-1:0];
      draw_col_ff   <= draw_col_in;
      draw_row_ff   <= draw_row_in;
      draw_color_ff <= draw_color_in;
      draw_code_ff  <= draw_code_in;
      glyph_ff      <= glyph_in;
   end

   // glyph loads write in the accept cycle; a drawing request's fetches run in ST_READ
   assign mem_we = req_fire && (req_cmd == CMD_LOAD_ROW);

   tgpr_glyph_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr ({req_char, req_grow}),
      .wr_data (req_gbits),
      .rd_en   (mem_re),
      .rd_addr ({draw_code_ff, rd_cnt_ff[ROW_AW-1:0]}),
      .rd_data (mem_rdata)
   );

   assign job.col   = draw_col_ff;
   assign job.row   = draw_row_ff;
   assign job.color = draw_color_ff;
   assign job.bits  = glyph_ff;

   tgpr_pixel_gen u_pixel (
      .clock        (clock),
      .reset        (reset),
      .start        (job_start),
      .job          (job),
      .frame_base   (frame_base_ff),
      .screen_width (screen_width_ff),
      .busy         (draw_busy),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

   `TGPR_ASSERT_IMPLY(a_idle_not_drawing, clock, reset, state_ff == ST_IDLE, !draw_busy)
   `TGPR_ASSERT_IMPLY(a_read_data_in_read, clock, reset, rd_pend_ff, state_ff == ST_READ)
   `TGPR_ASSERT_IMPLY(a_launch_after_fetch, clock, reset, state_ff == ST_LAUNCH,
      rd_cnt_ff[ROW_AW] && !rd_pend_ff)

endmodule

// ===== rtl/core/tgpr_glyph_store.sv =====
// Glyph row store: one write port, one registered read port.
// Depends on tgpr_pkg for the store geometry.
module tgpr_glyph_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [tgpr_pkg::STORE_AW-1:0] wr_addr,
   input  logic [tgpr_pkg::GLYPH_COLS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [tgpr_pkg::STORE_AW-1:0] rd_addr,
   output logic [tgpr_pkg::GLYPH_COLS-1:0] rd_data
);
   import tgpr_pkg::*;

   logic [GLYPH_COLS-1:0] mem_ff [STORE_DEPTH];
   logic [GLYPH_COLS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tgpr_pixel_gen.sv =====
// Pixel write generator: scans a glyph column-major, one bit a cycle unless the
// output stalls, and emits a pixel write for every set bit through an output register.
// Depends on tgpr_pkg and the assertion macro header.
`include "text_glyph_pixel_renderer_macros.svh"
module tgpr_pixel_gen (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  tgpr_pkg::draw_job_type             job,
   input  logic [31:0]                        frame_base,
   input  logic [12:0]                        screen_width,
   output logic                               busy,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tgpr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);
   import tgpr_pkg::*;

   // cell origin, refreshed every cycle from the held cell position
   logic [24:0]           ybase_ff;
   logic [31:0]           cell_addr_ff;

   // scan state
   logic                  active_ff, active_in;
   logic [GLYPH_BITS-1:0] bits_ff, bits_in;
   logic [ROW_AW-1:0]     gx_ff, gx_in;
   logic [ROW_AW-1:0]     gy_ff, gy_in;
   logic [15:0]           yoff_ff, yoff_in;
   logic [31:0]           color_ff, color_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_addr_ff, rsp_addr_in;
   logic [31:0]           rsp_color_ff, rsp_color_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_ready;
   logic                  step;
   logic [BIT_AW-1:0]     idx;
   logic                  cur;
   logic [GLYPH_BITS-1:0] rest;
   logic [31:0]           pix_addr;

   // cell origin: base + 4*(col*8 + row*8*width)
   always_ff @(posedge clock) begin
      ybase_ff     <= 25'({job.row, 3'b000}) * 25'(screen_width);
      cell_addr_ff <= frame_base
                      + {4'b0000, ({1'b0, ybase_ff} + 26'({job.col, 3'b000})), 2'b00};
   end

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign step      = active_ff && out_ready;
   assign idx       = {gx_ff, gy_ff};
   assign cur       = bits_ff[idx];
   assign rest      = bits_ff & ~(GLYPH_BITS'(1) << idx);
   assign pix_addr  = cell_addr_ff + 32'({gx_ff, 2'b00}) + 32'({yoff_ff, 2'b00});

   // scan and output register next values
   always_comb begin
      active_in    = active_ff;
      bits_in      = bits_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      yoff_in      = yoff_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (start) begin
         active_in = (job.bits != '0);
         bits_in   = job.bits;
         gx_in     = '0;
         gy_in     = '0;
         yoff_in   = '0;
         color_in  = job.color;
      end else if (step) begin
         if (cur) begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = pix_addr;
            rsp_color_in = color_ff;
            rsp_last_in  = (rest == '0);
         end
         bits_in   = rest;
         active_in = (rest != '0);
         // glyph row is the inner loop
         if (gy_ff == ROW_AW'(GLYPH_ROWS - 1)) begin
            gy_in   = '0;
            gx_in   = gx_ff + 1'b1;
            yoff_in = '0;
         end else begin
            gy_in   = gy_ff + 1'b1;
            yoff_in = 16'(yoff_ff + 16'(screen_width));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bits_ff      <= bits_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      yoff_ff      <= yoff_in;
      color_ff     <= color_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy       = active_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_color_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_last_ff;

   `TGPR_ASSERT_NEVER(a_start_while_active, clock, reset, start && active_ff)
   `TGPR_ASSERT_IMPLY(a_active_has_bits, clock, reset, active_ff, bits_ff != '0)
   `TGPR_ASSERT_NEXT(a_last_ends_scan, clock, reset, step && cur && (rest == '0),
      !active_ff && rsp_valid_ff && rsp_last_ff)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for text_glyph_pixel_renderer: stream requests in,
// pixel writes out, checked against an in-bench console and font predictor.
// Depends on tgpr_pkg and the renderer RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tgpr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 100;
   // command code the block ignores
   localparam logic [1:0] CMD_IGNORED = 2'd3;

   // one console request, fields as on the request channel
   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  code;
      logic [31:0] color;
      logic [8:0]  col;
      logic [8:0]  row;
      logic [2:0]  gidx;
      logic [7:0]  gbits;
   } console_cmd_type;

   // one pixel write as seen on the result channel
   typedef struct {
      logic [31:0] addr;
      logic [31:0] color;
      logic        last;
   } pixel_write_type;

   // directed step: typed rows carry their own expectation (none or one pixel)
   typedef struct {
      console_cmd_type req;
      bit              typed;
      int              exp_n;
      logic [31:0]     exp_addr;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   text_glyph_pixel_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // console mirror: registers, cursor and font
   logic [31:0] frame_base_m = 32'd0;
   logic [12:0] screen_width_m = SCREEN_WIDTH_RESET;
   logic [31:0] bg_color_m = 32'd0;
   logic [8:0]  cursor_col_m = 9'd0;
   logic [8:0]  cursor_row_m = 9'd0;
   logic [7:0]  font_rows [0:255][0:7];
   logic [7:0]  rows_loaded [0:255];
   bit          glyph_ready [0:255];
   int          ready_codes [$];

   pixel_write_type frame_writes [$];
   pixel_write_type pixels_due [$];
   pixel_write_type oldest_write;

   int mismatches = 0;
   int requests_done = 0;
   int pixels_checked = 0;
   int setups_run = 1;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_limit = 2;
   int ready_tick = 0;

   script_row_type script [20] = '{
      '{'{CMD_PUT, CODE_NEWLINE, 32'h0, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_SET_CURSOR, 8'd0, 32'h0, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_PUT, CODE_BACKSPACE, 32'h0, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_PUT, 8'd1, 32'hFFFF_FFFF, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 1, 32'd28700},
      '{'{CMD_PUT, 8'd1, 32'h0000_0000, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 1, 32'd28732},
      '{'{CMD_PUT, CODE_BACKSPACE, 32'h0, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b0, 0, 32'd0},
      '{'{CMD_SET_CURSOR, 8'd0, 32'h0, 9'd511, 9'd511, 3'd0, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_PUT, 8'd1, 32'h1234_5678, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 1, 32'd28700},
      '{'{CMD_SET_CURSOR, 8'd0, 32'h0, 9'd200, 9'd3, 3'd0, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_PUT, CODE_BACKSPACE, 32'h0, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b0, 0, 32'd0},
      '{'{CMD_PUT, GLYPH_SOLID, 32'hA5A5_A5A5, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b0, 0, 32'd0},
      '{'{CMD_PUT, 8'd1, 32'h0F0F_0F0F, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 1, 32'd159772},
      '{'{CMD_LOAD_ROW, 8'd1, 32'h0, 9'd0, 9'd0, 3'd7, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_PUT, 8'd1, 32'h5555_AAAA, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_SET_CURSOR, 8'd0, 32'h0, 9'd5, 9'd511, 3'd0, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_PUT, CODE_NEWLINE, 32'h0, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b1, 0, 32'd0},
      '{'{CMD_IGNORED, 8'd65, 32'hFFFF_FFFF, 9'd511, 9'd511, 3'd7, 8'hFF}, 1'b1, 0, 32'd0},
      '{'{CMD_LOAD_ROW, 8'd255, 32'h0, 9'd0, 9'd0, 3'd7, 8'hFF}, 1'b1, 0, 32'd0},
      '{'{CMD_LOAD_ROW, 8'd1, 32'h0, 9'd0, 9'd0, 3'd3, 8'h81}, 1'b1, 0, 32'd0},
      '{'{CMD_PUT, 8'd1, 32'h0000_0000, 9'd0, 9'd0, 3'd0, 8'h00}, 1'b0, 0, 32'd0}
   };

   // column-major scan of one glyph at the cursor into frame_writes
   function automatic void paint_glyph(input logic [7:0] code, input logic [31:0] color);
      logic [31:0] x;
      logic [31:0] y;
      for (int gx = 0; gx < GLYPH_COLS; gx++) begin
         for (int gy = 0; gy < GLYPH_ROWS; gy++) begin
            if (font_rows[code][gy][gx]) begin
               x = 32'(cursor_col_m) * 32'd8 + 32'(gx);
               y = 32'(cursor_row_m) * 32'd8 + 32'(gy);
               frame_writes.push_back('{frame_base_m + 32'd4 * (x + y * 32'(screen_width_m)),
                                        color, 1'b0});
            end
         end
      end
      if (frame_writes.size() > 0) frame_writes[frame_writes.size() - 1].last = 1'b1;
   endfunction

   // console update for one accepted request; pixel writes land in frame_writes
   function automatic void render_request(input console_cmd_type item);
      int cells;
      int c;
      frame_writes.delete();
      cells = int'(screen_width_m) / GLYPH_COLS;
      case (item.cmd)
         CMD_SET_CURSOR: begin
            cursor_col_m = item.col;
            cursor_row_m = item.row;
         end
         CMD_LOAD_ROW: begin
            font_rows[item.code][item.gidx] = item.gbits;
            rows_loaded[item.code][item.gidx] = 1'b1;
            if (rows_loaded[item.code] == 8'hFF && !glyph_ready[item.code]) begin
               glyph_ready[item.code] = 1'b1;
               ready_codes.push_back(int'(item.code));
            end
         end
         CMD_PUT: begin
            if (item.code == CODE_NEWLINE) begin
               cursor_col_m = 9'd0;
               cursor_row_m = cursor_row_m + 9'd1;
            end else if (item.code == CODE_BACKSPACE) begin
               // past the line end the column first clamps to the line length
               c = (int'(cursor_col_m) < cells) ? int'(cursor_col_m) : cells;
               if (c != 0) begin
                  cursor_col_m = 9'(c - 1);
                  paint_glyph(GLYPH_SOLID, bg_color_m);
               end
            end else begin
               // wrap first, then draw at the new cell
               if (int'(cursor_col_m) >= cells) begin
                  cursor_col_m = 9'd0;
                  cursor_row_m = cursor_row_m + 9'd1;
               end
               paint_glyph(item.code, item.color);
               cursor_col_m = cursor_col_m + 9'd1;
            end
         end
         default: ;
      endcase
   endfunction

   // drive one request, predict on acceptance, then maybe open a gap
   task automatic send_request(input console_cmd_type item, input bit typed,
                               input int exp_n, input logic [31:0] exp_addr);
      req_tvalid <= 1'b1;
      req_tuser  <= item.cmd;
      req_tdata  <= {3'b000, item.gbits, item.gidx, item.row, item.col, item.color, item.code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      render_request(item);
      if (typed) begin
         if (exp_n == 1) pixels_due.push_back('{exp_addr, item.color, 1'b1});
      end else begin
         foreach (frame_writes[i]) pixels_due.push_back(frame_writes[i]);
      end
      requests_done++;
      if (gap_limit != 0 && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, gap_limit)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end else if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   // stop sending and wait until every predicted pixel write has come out
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_setup(input logic [31:0] base, input logic [12:0] width,
                              input logic [31:0] bg);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= {19'd0, width};
      @(posedge clock);
      csr_index <= CSR_BG_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we <= 1'b0;
      frame_base_m   = base;
      screen_width_m = width;
      bg_color_m     = bg;
      setups_run++;
   endtask

   function automatic console_cmd_type noise_fields();
      console_cmd_type c;
      c.cmd   = CMD_PUT;
      c.code  = 8'($urandom);
      c.color = $urandom;
      c.col   = 9'($urandom);
      c.row   = 9'($urandom);
      c.gidx  = 3'($urandom);
      c.gbits = 8'($urandom);
      return c;
   endfunction

   // mostly text on loaded glyphs, plus cursor moves, font loads and noise
   task automatic run_random_phase(input int n_items);
      console_cmd_type c;
      int issued;
      int pick;
      int cells;
      int shape;
      logic [7:0] glyph;
      issued = 0;
      while (issued < n_items) begin
         c = noise_fields();
         pick = $urandom_range(0, 99);
         cells = int'(screen_width_m) / GLYPH_COLS;
         if (pick < 45) begin
            c.code = 8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
         end else if (pick < 55) begin
            c.code = CODE_NEWLINE;
         end else if (pick < 65) begin
            c.code = CODE_BACKSPACE;
         end else if (pick < 75) begin
            c.cmd = CMD_SET_CURSOR;
            shape = $urandom_range(0, 3);
            if (shape == 0) c.col = 9'd511 - 9'($urandom_range(0, 1));
            else if (shape == 1) c.col = 9'((cells > 511) ? 511 : $urandom_range(0, cells));
            if ($urandom_range(0, 4) == 0) c.row = 9'd511;
         end else if (pick < 85) begin
            // whole glyph, row by row, with a random density
            glyph = 8'($urandom);
            shape = $urandom_range(0, 3);
            for (int r = 0; r < GLYPH_ROWS; r++) begin
               c = noise_fields();
               c.cmd  = CMD_LOAD_ROW;
               c.code = glyph;
               c.gidx = 3'(r);
               if (shape == 1) c.gbits = 8'($urandom & $urandom & $urandom);
               else if (shape == 2) c.gbits = 8'hFF;
               else if (shape == 3) c.gbits = 8'h00;
               send_request(c, 1'b0, 0, 32'd0);
            end
            issued += GLYPH_ROWS;
            continue;
         end else if (pick < 97) begin
            c.cmd = CMD_LOAD_ROW;
         end else begin
            c.cmd = CMD_IGNORED;
            issued--;
         end
         send_request(c, 1'b0, 0, 32'd0);
         issued++;
      end
   endtask

   // result checker: oldest expectation first, field by field
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixels_due.size() == 0) begin
            $error("unexpected pixel write: address %h color %h", rsp_tdata[31:0],
                   rsp_tdata[63:32]);
            mismatches++;
         end else begin
            oldest_write = pixels_due.pop_front();
            pixels_checked++;
            if (rsp_tdata[31:0] !== oldest_write.addr) begin
               $error("pixel_address: expected %h, got %h", oldest_write.addr,
                      rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tdata[63:32] !== oldest_write.color) begin
               $error("pixel_color: expected %h, got %h", oldest_write.color,
                      rsp_tdata[63:32]);
               mismatches++;
            end
            if (rsp_tlast !== oldest_write.last) begin
               $error("last_pixel: expected %b, got %b", oldest_write.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // receiver: rotates through always ready, random stalls and a fixed pattern
   always @(posedge clock) begin
      ready_tick++;
      case ((ready_tick / 256) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 99) < 70);
         2: rsp_tready <= ((ready_tick % 9) > 2);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      for (int g = 0; g < 256; g++) begin
         rows_loaded[g] = 8'h00;
         glyph_ready[g] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // font setup: solid block for backspace, glyph 1 with a single corner pixel
      for (int r = 0; r < GLYPH_ROWS; r++)
         send_request('{CMD_LOAD_ROW, GLYPH_SOLID, 32'h0, 9'd0, 9'd0, 3'(r), 8'hFF},
                      1'b1, 0, 32'd0);
      for (int r = 0; r < GLYPH_ROWS; r++)
         send_request('{CMD_LOAD_ROW, 8'd1, 32'h0, 9'd0, 9'd0, 3'(r),
                        (r == 7) ? 8'h80 : 8'h00}, 1'b1, 0, 32'd0);

      // directed steps at the reset register values
      foreach (script[i])
         send_request(script[i].req, script[i].typed, script[i].exp_n, script[i].exp_addr);
      drain(SETTLE_CYCLES);

      // narrowest screen, base near the top of the address space
      gap_limit = 4;
      write_setup(32'hFFFF_FFF0, 13'd8, 32'hFFFF_FFFF);
      run_random_phase(26);
      drain(SETTLE_CYCLES);

      // widest screen, sender never idles
      gap_limit = 0;
      write_setup(32'h0000_0000, 13'd4096, 32'h0000_0000);
      run_random_phase(26);
      drain(SETTLE_CYCLES);

      // random setup, with a full pause in the middle
      gap_limit = 6;
      write_setup($urandom, 13'($urandom_range(8, 4096)), $urandom);
      run_random_phase(13);
      drain(0);
      run_random_phase(13);
      drain(SETTLE_CYCLES);

      // random setup on small screens, where wraps are frequent
      gap_limit = 3;
      write_setup($urandom, 13'($urandom_range(8, 200)), $urandom);
      run_random_phase(26);
      drain(SETTLE_CYCLES);

      if (pixels_due.size() != 0) begin
         $error("%0d pixel writes never arrived", pixels_due.size());
         mismatches++;
      end
      $display("Sent %0d requests over %0d screen setups; checked %0d pixel writes.",
               requests_done, setups_run, pixels_checked);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tgpr_pkg.sv
rtl/core/tgpr_glyph_store.sv
rtl/core/tgpr_pixel_gen.sv
rtl/core/text_glyph_pixel_renderer.sv
dv/tb_top.sv
